// ===== hdl/stick_calibrate_and_scale_macros.svh =====
// Assertion shorthands shared by the block's modules.
// Each expects clk and rst_n in scope.
`ifndef STICK_CALIBRATE_AND_SCALE_MACROS_SVH
`define STICK_CALIBRATE_AND_SCALE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scm_pkg.sv =====
`timescale 1ns / 1ps

package scm_pkg;

  // Axis layout: aileron, elevator, throttle, rudder
  localparam int N_AXES = 4;
  localparam int AX_W   = 2;
  localparam logic [AX_W-1:0] AX_RUDDER = 2'd3;

  // Field widths
  localparam int RAW_W  = 10;
  localparam int OFF_W  = 9;
  localparam int CHAN_W = 11;
  localparam int IDX_W  = 3;

  // Stream widths
  localparam int IN_DATA_W  = N_AXES * RAW_W;   // 40, whole bytes
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;               // 44 bits used, zero filled

  // Extremes
  localparam int ADC_CUTOFF = 10;
  localparam int RAW_FULL   = 1023;
  localparam logic [RAW_W-1:0] EXT_LOW_RST  = RAW_W'(ADC_CUTOFF);
  localparam logic [RAW_W-1:0] EXT_HIGH_RST = RAW_W'(RAW_FULL - ADC_CUTOFF);
  localparam logic [RAW_W-1:0] EXT_CENTRE   = RAW_W'((RAW_FULL - 2 * ADC_CUTOFF) / 2);

  // Channel limit reset values
  localparam logic [CHAN_W-1:0] CHAN_LOW_RST  = 11'd172;
  localparam logic [CHAN_W-1:0] CHAN_HIGH_RST = 11'd1811;

  // Datapath widths
  localparam int X_W    = 12;  // raw + offset, signed
  localparam int SPAN_W = 12;  // channel span, signed
  localparam int DEN_W  = 11;  // extreme difference, signed
  localparam int PROD_W = 24;  // diff * span, signed
  localparam int NUM_W  = 22;  // |product| < 2^22
  localparam int DMAG_W = 10;  // |extreme difference| <= 1023
  localparam int M_W    = 25;  // mapped value before clamp, signed

  // Divider: two quotient bits per step
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int CNT_W     = 4;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_AIL_OFF  = 3'd0,
    REG_ELE_OFF  = 3'd1,
    REG_THR_OFF  = 3'd2,
    REG_RUD_OFF  = 3'd3,
    REG_CHAN_LO  = 3'd4,
    REG_CHAN_HI  = 3'd5
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_PUSH
  } seq_state_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DMAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/scm_div.sv =====
`timescale 1ns / 1ps

// Unsigned restoring divider, two quotient bits per cycle.
// The quotient builds up in the dividend shift register.
module scm_div (
  input  logic            clk,
  input  logic            rst_n,
  input  scm_pkg::div_req_t req_i,
  output scm_pkg::div_rsp_t rsp_o
);
  import scm_pkg::*;

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DMAG_W-1:0] den_r;
  logic [DMAG_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DMAG_W:0] t1, t2, r1, r2, den_x;
  logic            ge1, ge2;

  // Two trial subtractions per cycle
  always_comb begin
    den_x   = {1'b0, den_r};
    t1      = {rem_r, num_r[NUM_W-1]};
    ge1     = (t1 >= den_x);
    r1      = ge1 ? (t1 - den_x) : t1;
    t2      = {r1[DMAG_W-1:0], num_r[NUM_W-2]};
    ge2     = (t2 >= den_x);
    r2      = ge2 ? (t2 - den_x) : t2;
    num_nxt = {num_r[NUM_W-3:0], ge1, ge2};
    rem_nxt = r2[DMAG_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      num_r <= req_i.num;
      den_r <= req_i.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quo  = num_r;

endmodule

// ===== hdl/stick_calibrate_and_scale.sv =====
`timescale 1ns / 1ps
`include "stick_calibrate_and_scale_macros.svh"

// Stick calibration and scaling. Each request carries four 10-bit stick samples
// (aileron, elevator, throttle, rudder) plus two flags in in_tuser; each yields
// one result of four 11-bit channel values. While calibrating, the stored
// per-axis extremes are widened by the sample (optionally first reset to centre),
// then each sample plus its signed offset is mapped linearly from the extremes
// onto [channel_low, channel_high], truncating towards zero, and clamped.
// Aileron, elevator and throttle are reversed. After acceptance the four axes
// go in turn through the operand, multiply and divider start states and a wait
// in the shared divider, which resolves two quotient bits a cycle; then the
// push state loads the output register, waiting while the output is stalled.
// The block takes no new request until the previous result has moved to the
// output register, so it is through with one request before it takes the next.
// Configuration writes are always accepted and must be made while idle.
module stick_calibrate_and_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  // Samples
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // aileron_raw, elevator_raw, throttle_raw, rudder_raw
  input  logic [scm_pkg::IN_DATA_W-1:0] in_tdata,
  // calibrating, cal_first
  input  logic [scm_pkg::IN_USER_W-1:0] in_tuser,
  // Channels
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // aileron_chan, elevator_chan, throttle_chan, rudder_chan, zero fill
  output logic [scm_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [scm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [scm_pkg::CHAN_W-1:0]    cfg_data
);
  import scm_pkg::*;

  // Configuration registers
  logic [OFF_W-1:0]  off_r [N_AXES];
  logic [CHAN_W-1:0] chan_lo_r;
  logic [CHAN_W-1:0] chan_hi_r;

  // Extremes and captured samples
  logic [RAW_W-1:0] ext_low_r  [N_AXES];
  logic [RAW_W-1:0] ext_high_r [N_AXES];
  logic [RAW_W-1:0] ext_low_nxt  [N_AXES];
  logic [RAW_W-1:0] ext_high_nxt [N_AXES];
  logic [RAW_W-1:0] raw_r [N_AXES];

  // Sequencer
  seq_state_t      state_r, state_nxt;
  logic [AX_W-1:0] ax_r;
  logic            in_acc;
  logic            out_load;

  // Datapath registers
  logic signed [X_W-1:0]    diff_r;
  logic signed [DEN_W-1:0]  den_r;
  logic                     zero_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic [CHAN_W-1:0]        chan_r [N_AXES];
  logic                     out_tvalid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  // Datapath logic
  logic [RAW_W-1:0]         sel_raw, sel_lo, sel_hi, map_from, map_to;
  logic [OFF_W-1:0]         sel_off;
  logic                     rev;
  logic signed [X_W-1:0]    x_s, diff_s;
  logic signed [DEN_W-1:0]  den_s;
  logic signed [SPAN_W-1:0] span_s;
  logic [PROD_W-1:0]        prod_mag;
  logic [DEN_W-1:0]         den_mag;
  logic signed [M_W-1:0]    q_s, qsig_s, m_s, clo_s, chi_s;
  logic [CHAN_W-1:0]        chan_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  scm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_AXES; i++) begin
        off_r[i] <= '0;
      end
      chan_lo_r <= CHAN_LOW_RST;
      chan_hi_r <= CHAN_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AIL_OFF: off_r[0]  <= cfg_data[OFF_W-1:0];
        REG_ELE_OFF: off_r[1]  <= cfg_data[OFF_W-1:0];
        REG_THR_OFF: off_r[2]  <= cfg_data[OFF_W-1:0];
        REG_RUD_OFF: off_r[3]  <= cfg_data[OFF_W-1:0];
        REG_CHAN_LO: chan_lo_r <= cfg_data;
        REG_CHAN_HI: chan_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Calibration: optional reset to centre, then widen by the sample
  always_comb begin
    logic [RAW_W-1:0] raw_i, base_lo, base_hi;
    for (int i = 0; i < N_AXES; i++) begin
      raw_i   = in_tdata[i*RAW_W +: RAW_W];
      base_lo = in_tuser[1] ? EXT_CENTRE : ext_low_r[i];
      base_hi = in_tuser[1] ? EXT_CENTRE : ext_high_r[i];
      ext_low_nxt[i]  = (raw_i < base_lo) ? raw_i : base_lo;
      ext_high_nxt[i] = (raw_i > base_hi) ? raw_i : base_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_AXES; i++) begin
        ext_low_r[i]  <= EXT_LOW_RST;
        ext_high_r[i] <= EXT_HIGH_RST;
      end
    end else if (in_acc && in_tuser[0]) begin
      for (int i = 0; i < N_AXES; i++) begin
        ext_low_r[i]  <= ext_low_nxt[i];
        ext_high_r[i] <= ext_high_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < N_AXES; i++) begin
        raw_r[i] <= in_tdata[i*RAW_W +: RAW_W];
      end
    end
  end

  // Operands for the current axis
  always_comb begin
    sel_raw  = raw_r[ax_r];
    sel_off  = off_r[ax_r];
    sel_lo   = ext_low_r[ax_r];
    sel_hi   = ext_high_r[ax_r];
    rev      = (ax_r != AX_RUDDER);
    map_from = rev ? sel_hi : sel_lo;
    map_to   = rev ? sel_lo : sel_hi;
    x_s      = $signed({2'b00, sel_raw})
             + $signed({{(X_W-OFF_W){sel_off[OFF_W-1]}}, sel_off});
    diff_s   = x_s - $signed({2'b00, map_from});
    den_s    = $signed({1'b0, map_to}) - $signed({1'b0, map_from});
    span_s   = $signed({1'b0, chan_hi_r}) - $signed({1'b0, chan_lo_r});
    prod_mag = prod_r[PROD_W-1] ? (~prod_r + 1'b1) : prod_r;
    den_mag  = den_r[DEN_W-1] ? (~den_r + 1'b1) : den_r;
  end

  // Sign restore, offset, clamp
  always_comb begin
    q_s    = $signed({{(M_W-NUM_W){1'b0}}, div_rsp.quo});
    qsig_s = neg_r ? -q_s : q_s;
    clo_s  = $signed({{(M_W-CHAN_W){1'b0}}, chan_lo_r});
    chi_s  = $signed({{(M_W-CHAN_W){1'b0}}, chan_hi_r});
    m_s    = zero_r ? clo_s : (qsig_s + clo_s);
    if (m_s < clo_s) begin
      chan_val = chan_lo_r;
    end else if (m_s > chi_s) begin
      chan_val = chan_hi_r;
    end else begin
      chan_val = m_s[CHAN_W-1:0];
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ax_r <= '0;
      end else if (state_r == ST_DIV && div_rsp.done) begin
        ax_r <= ax_r + 1'b1;
      end
    end
  end

  // Next state and control
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = prod_mag[NUM_W-1:0];
    div_req.den   = den_mag[DMAG_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (ax_r == AX_RUDDER) ? ST_PUSH : ST_LOAD;
        end
      end
      ST_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Per-axis datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        diff_r <= diff_s;
        den_r  <= den_s;
        zero_r <= (map_to == map_from);
      end
      ST_MUL: prod_r <= diff_r * span_s;
      ST_DSTART: neg_r <= prod_r[PROD_W-1] ^ den_r[DEN_W-1];
      ST_DIV: begin
        if (div_rsp.done) begin
          chan_r[ax_r] <= chan_val;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{(OUT_DATA_W - N_AXES*CHAN_W){1'b0}},
                     chan_r[3], chan_r[2], chan_r[1], chan_r[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `SCM_ASSERT_NEXT(a_accept_starts_axis0, in_acc,
    state_r == ST_LOAD && ax_r == '0, "request accepted but sequencer not at first axis")
  `SCM_ASSERT_SAME(a_div_done_in_wait, div_rsp.done,
    state_r == ST_DIV, "divider finished outside the wait state")
  `SCM_ASSERT_SAME(a_extremes_ordered, 1'b1,
    ext_low_r[0] <= ext_high_r[0] && ext_low_r[1] <= ext_high_r[1] &&
    ext_low_r[2] <= ext_high_r[2] && ext_low_r[3] <= ext_high_r[3],
    "low extreme above high extreme")
  `SCM_ASSERT_NEXT(a_push_offers_result, out_load,
    out_tvalid_r && state_r == ST_IDLE, "finished result not offered")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import scm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 200;
  localparam int CENTRE         = (RAW_FULL - 2 * ADC_CUTOFF) / 2;
  // Indexes beyond the register file; writes to them must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic                         cal;
    logic                         first;
    logic [N_AXES-1:0][RAW_W-1:0] raw;
  } stick_sample_t;

  typedef logic [N_AXES-1:0][CHAN_W-1:0] chan_set_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index  = '0;
  logic [CHAN_W-1:0]     cfg_data   = '0;

  // Predictor copy of extremes and registers
  int ext_low [N_AXES];
  int ext_high[N_AXES];
  int trim    [N_AXES];
  int lim_lo;
  int lim_hi;

  chan_set_t channels_due[$];
  bit        no_gaps = 1'b0;
  int        rx_hold = 0;
  int        idle_cycles = 0;
  int        fail_count = 0;
  int        sent_count = 0;
  int        cal_count = 0;
  int        result_count = 0;
  int        write_count = 0;

  always #6 clk = ~clk;

  stick_calibrate_and_scale i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic string axis_name(int i);
    case (i)
      0: return "aileron";
      1: return "elevator";
      2: return "throttle";
      default: return "rudder";
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < N_AXES; i++) begin
      ext_low[i]  = ADC_CUTOFF;
      ext_high[i] = RAW_FULL - ADC_CUTOFF;
      trim[i]     = 0;
    end
    lim_lo = int'(CHAN_LOW_RST);
    lim_hi = int'(CHAN_HIGH_RST);
  endfunction

  // Linear map from [from, to] onto the channel limits, then floor and ceiling
  function automatic int map_to_channel(int x, int from, int to);
    longint m;
    if (to == from) begin
      m = lim_lo;
    end else begin
      m = longint'(x - from) * longint'(lim_hi - lim_lo) / longint'(to - from) + lim_lo;
    end
    if (m < lim_lo) begin
      m = lim_lo;
    end else if (m > lim_hi) begin
      m = lim_hi;
    end
    return int'(m);
  endfunction

  // Widen extremes if calibrating, then map every axis
  function automatic chan_set_t predict_channels(stick_sample_t s);
    chan_set_t res;
    int        x;
    if (s.cal) begin
      if (s.first) begin
        for (int i = 0; i < N_AXES; i++) begin
          ext_low[i]  = CENTRE;
          ext_high[i] = CENTRE;
        end
      end
      for (int i = 0; i < N_AXES; i++) begin
        if (int'(s.raw[i]) < ext_low[i]) ext_low[i] = int'(s.raw[i]);
        if (int'(s.raw[i]) > ext_high[i]) ext_high[i] = int'(s.raw[i]);
      end
    end
    for (int i = 0; i < N_AXES; i++) begin
      x = int'(s.raw[i]) + trim[i];
      if (i == int'(AX_RUDDER)) begin
        res[i] = CHAN_W'(map_to_channel(x, ext_low[i], ext_high[i]));
      end else begin
        res[i] = CHAN_W'(map_to_channel(x, ext_high[i], ext_low[i]));
      end
    end
    return res;
  endfunction

  function automatic stick_sample_t make_sample(bit cal, bit first, int lo, int hi);
    stick_sample_t s;
    s.cal   = cal;
    s.first = first;
    for (int i = 0; i < N_AXES; i++) s.raw[i] = RAW_W'($urandom_range(hi, lo));
    return s;
  endfunction

  function automatic stick_sample_t fixed_sample(bit cal, bit first, int a, int e, int t, int r);
    stick_sample_t s;
    s.cal   = cal;
    s.first = first;
    s.raw   = {RAW_W'(r), RAW_W'(t), RAW_W'(e), RAW_W'(a)};
    return s;
  endfunction

  // Offset register word; the two spare top bits carry random junk
  function automatic logic [CHAN_W-1:0] offset_word(int off);
    return {2'($urandom_range(3, 0)), OFF_W'(off)};
  endfunction

  // Send one request; valid stays high between back-to-back requests
  task automatic send_sample(input stick_sample_t s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s.raw;
    in_tuser  <= {s.first, s.cal};
    do @(posedge clk); while (!in_tready);
    channels_due.push_back(predict_channels(s));
    sent_count++;
    if (s.cal) cal_count++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (channels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CHAN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AIL_OFF, REG_ELE_OFF, REG_THR_OFF, REG_RUD_OFF: begin
        trim[idx[AX_W-1:0]] = int'($signed(data[OFF_W-1:0]));
      end
      REG_CHAN_LO: lim_lo = int'(data);
      REG_CHAN_HI: lim_hi = int'(data);
      default: ;
    endcase
    write_count++;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // Reset values, raw extremes and cutoff points, no calibration
  task automatic test_reset_defaults();
    send_sample(fixed_sample(0, 0, 0, 0, 0, 0));
    send_sample(fixed_sample(0, 0, 1023, 1023, 1023, 1023));
    send_sample(fixed_sample(0, 0, ADC_CUTOFF, RAW_FULL - ADC_CUTOFF, CENTRE, 0));
    send_sample(fixed_sample(0, 0, RAW_FULL - ADC_CUTOFF, ADC_CUTOFF, 1023, CENTRE));
  endtask

  task automatic test_calibration();
    // first flag alone must leave the extremes untouched
    send_sample(fixed_sample(0, 1, 0, 0, 0, 0));
    // reset to centre with centre samples: zero span on every axis
    send_sample(fixed_sample(1, 1, CENTRE, CENTRE, CENTRE, CENTRE));
    send_sample(fixed_sample(0, 0, 0, 1023, 200, 900));
    // widen to the full range
    send_sample(fixed_sample(1, 0, 0, 0, 0, 0));
    send_sample(fixed_sample(1, 0, 1023, 1023, 1023, 1023));
    send_sample(fixed_sample(0, 0, 0, 512, 1023, 777));
    // narrow window around the centre
    send_sample(fixed_sample(1, 1, 300, 450, 520, 700));
    send_sample(fixed_sample(1, 0, 700, 600, 480, 300));
    send_sample(fixed_sample(0, 0, 1023, 0, 500, 650));
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_reg(REG_AIL_OFF, offset_word(-255));
    write_reg(REG_ELE_OFF, offset_word(-255));
    write_reg(REG_THR_OFF, offset_word(-255));
    write_reg(REG_RUD_OFF, offset_word(-255));
    write_reg(REG_CHAN_LO, 11'd0);
    write_reg(REG_CHAN_HI, 11'd2047);
    end_writes();
    send_sample(fixed_sample(1, 1, 0, 1023, 0, 1023));
    send_sample(fixed_sample(1, 0, 1023, 0, 1023, 0));
    drain_results();
    // positive offsets and crossed channel limits
    write_reg(REG_AIL_OFF, offset_word(255));
    write_reg(REG_ELE_OFF, offset_word(255));
    write_reg(REG_THR_OFF, offset_word(255));
    write_reg(REG_RUD_OFF, offset_word(255));
    write_reg(REG_CHAN_LO, 11'd1811);
    write_reg(REG_CHAN_HI, 11'd172);
    end_writes();
    send_sample(fixed_sample(0, 0, 0, 1023, 400, 800));
    send_sample(fixed_sample(0, 0, 1023, 0, 800, 400));
    drain_results();
    // unused indexes are ignored
    write_reg(REG_SPARE_A, CHAN_W'($urandom_range(2047, 0)));
    write_reg(REG_SPARE_B, CHAN_W'($urandom_range(2047, 0)));
    end_writes();
    send_sample(fixed_sample(0, 0, 512, 256, 768, 1023));
  endtask

  task automatic configure_random();
    int pick;
    int lo;
    int hi;
    for (int i = 0; i < N_AXES; i++) begin
      pick = $urandom_range(5, 0);
      case (pick)
        0: write_reg(IDX_W'(i), offset_word(-255));
        1: write_reg(IDX_W'(i), offset_word(255));
        2: write_reg(IDX_W'(i), offset_word(0));
        3: write_reg(IDX_W'(i), offset_word(-256));
        default: write_reg(IDX_W'(i), offset_word($urandom_range(511, 0) - 256));
      endcase
    end
    pick = $urandom_range(5, 0);
    case (pick)
      0: begin lo = int'(CHAN_LOW_RST); hi = int'(CHAN_HIGH_RST); end
      1: begin lo = 0; hi = 2047; end
      2: begin lo = $urandom_range(2047, 1024); hi = $urandom_range(1023, 0); end
      3: begin lo = $urandom_range(2047, 0); hi = lo; end
      default: begin lo = $urandom_range(1023, 0); hi = $urandom_range(2047, 1024); end
    endcase
    write_reg(REG_CHAN_LO, CHAN_W'(lo));
    write_reg(REG_CHAN_HI, CHAN_W'(hi));
    if ($urandom_range(2, 0) == 0) write_reg(REG_SPARE_A, CHAN_W'($urandom_range(2047, 0)));
    if ($urandom_range(2, 0) == 0) write_reg(REG_SPARE_B, CHAN_W'($urandom_range(2047, 0)));
    end_writes();
  endtask

  // Mostly calibration sessions followed by use, with some noise in between
  task automatic test_random_use();
    int phase_sent;
    int sweeps;
    int uses;
    int half;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      configure_random();
      no_gaps    = (phase % 4 == 3);
      phase_sent = 0;
      while (phase_sent < PHASE_REQUESTS) begin
        if ($urandom_range(9, 0) < 7) begin
          half   = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 0) : 512;
          sweeps = $urandom_range(16, 0);
          uses   = $urandom_range(30, 5);
          send_sample(make_sample(1, 1, CENTRE - half < 0 ? 0 : CENTRE - half,
                                  CENTRE + half > 1023 ? 1023 : CENTRE + half));
          repeat (sweeps) begin
            send_sample(make_sample(1, 0, CENTRE - half < 0 ? 0 : CENTRE - half,
                                    CENTRE + half > 1023 ? 1023 : CENTRE + half));
          end
          repeat (uses) send_sample(make_sample(0, 0, 0, 1023));
          phase_sent += 1 + sweeps + uses;
        end else begin
          repeat (8) begin
            send_sample(make_sample($urandom_range(1, 0), $urandom_range(1, 0), 0, 1023));
          end
          phase_sent += 8;
        end
        // hold off now and then until the block has emptied
        if ($urandom_range(7, 0) == 0) drain_results();
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: a random stall before each result, none in quiet phases
  always @(posedge clk) begin
    int hold_next;
    hold_next = rx_hold;
    if (out_tvalid && out_tready) begin
      hold_next = no_gaps ? 0 : $urandom_range(6, 0);
    end else if (out_tvalid && hold_next > 0) begin
      hold_next--;
    end
    rx_hold    <= hold_next;
    out_tready <= (hold_next == 0);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    chan_set_t want;
    chan_set_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[N_AXES*CHAN_W-1:0];
      result_count++;
      if (channels_due.size() == 0) begin
        note_failure($sformatf("result with nothing expected: %h", got));
      end else begin
        want = channels_due.pop_front();
        for (int i = 0; i < N_AXES; i++) begin
          if (got[i] !== want[i]) begin
            note_failure($sformatf("%s channel expected %0d, got %0d",
                                   axis_name(i), want[i], got[i]));
          end
        end
      end
    end
  end

  // Watchdog: too long without any input, output or configuration handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, channels_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_calibration();
    test_register_extremes();
    test_random_use();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d stick samples (%0d calibrating) over %0d register writes,",
             sent_count, cal_count, write_count);
    $display("with offset and limit extremes, crossed limits and zero spans; %0d results, %0d failures",
             result_count, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
